// ----- rtl/core/stack_calculator_macros.svh -----
// Assertion macros used by the stack calculator port-level checker.
`ifndef STACK_CALCULATOR_MACROS_SVH
`define STACK_CALCULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STKC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STKC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/stkcalc_pkg.sv -----
// Types and constants shared by the stack calculator modules.
`default_nettype none

package stkcalc_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned DEPTH_OUT_W = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_DIV  = 3'd4,
    MODE_DROP = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2,
    STATUS_DIV_ZERO  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RUN,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic step;
    logic finish;
  } ctl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic long_op;
    logic step_last;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/stack_calculator.sv -----
// Top level of the stack calculator: controller plus datapath.
//
//   Channel   Strobe          Back-pressure   Payload
//   request   start           busy            mode_i, push_value_i
//   result    done_o          none            result_value_o, stack_depth_o, status_o
//
// Push, add, subtract, drop, unused modes and every flagged request end in the execute
// state after acceptance, which the registered read of the entry below the top needs.
// Multiply steps one 16-bit multiplier digit per cycle in the run state, then finishes.
// Divide steps one quotient bit per cycle in the run state, then finishes.
// Reset empties the stack at once; memory contents are not cleared and need no sweep.
// busy is low in the cycle that shows a result, so the next request is taken there.
`default_nettype none

module stack_calculator import stkcalc_pkg::*; #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [MODE_W-1:0]          mode_i,
  input  wire logic signed [VALUE_W-1:0]  push_value_i,
  output logic                            done_o,
  output logic signed [VALUE_W-1:0]       result_value_o,
  output logic [DEPTH_OUT_W-1:0]          stack_depth_o,
  output logic [STATUS_W-1:0]             status_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  stkcalc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  stkcalc_datapath #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .push_value_i   (push_value_i),
    .result_value_o (result_value_o),
    .stack_depth_o  (stack_depth_o),
    .status_o       (status_o),
    .done_o         (done_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/stkcalc_ctrl.sv -----
// Controller state machine that sequences one stack operation at a time.
`default_nettype none

module stkcalc_ctrl import stkcalc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire ctl_sts_t sts_i,
  output ctl_cmd_t      cmd_o,
  output logic          busy_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = sts_i.long_op ? ST_RUN : ST_IDLE;
      end
      ST_RUN: begin
        if (sts_i.step_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/stkcalc_datapath.sv -----
// Datapath: stack memory, cached top entry, shared multiply/divide unit, result registers.
`default_nettype none

module stkcalc_datapath import stkcalc_pkg::*; #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ctl_cmd_t                   cmd_i,
  output ctl_sts_t                        sts_o,
  input  wire logic [MODE_W-1:0]          mode_i,
  input  wire logic signed [VALUE_W-1:0]  push_value_i,
  output logic signed [VALUE_W-1:0]       result_value_o,
  output logic [DEPTH_OUT_W-1:0]          stack_depth_o,
  output logic [STATUS_W-1:0]             status_o,
  output logic                            done_o
);

  localparam int unsigned W       = ELEM_WIDTH;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  // Entries narrower than a full digit are multiplied in a single step.
  localparam int unsigned DIGIT_W = (W < 16) ? W : 16;
  localparam int unsigned NDIG    = (W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned IW      = $clog2(W);

  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [CW-1:0] TWO_C    = CW'(2);
  localparam logic [IW-1:0] MUL_LAST = IW'(NDIG - 1);
  localparam logic [IW-1:0] DIV_LAST = IW'(W - 1);

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // The top entry lives in tos_q; entries below it sit in the memory at their
  // stack index, so entry count minus two is always the second operand.
  logic [W-1:0]  mem [DEPTH];
  logic [W-1:0]  rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          mem_we;

  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [W-1:0]       pv_q, pv_d;
  logic [W-1:0]       tos_q, tos_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [W-1:0]       op_a_q, op_a_d;
  logic [W-1:0]       op_b_q, op_b_d;
  logic [W-1:0]       acc_q, acc_d;
  logic               neg_q, neg_d;
  logic [IW-1:0]      it_q, it_d;

  logic signed [VALUE_W-1:0] res_q, res_d;
  logic [DEPTH_OUT_W-1:0]    depth_q, depth_d;
  status_e                   status_q, status_d;
  logic                      done_q, done_d;

  logic [W-1:0] ex_value;
  logic         ex_long;
  logic         is_div;
  logic [W-1:0] mul_prod;
  logic [W-1:0] div_rem_sh;
  logic         div_ge;

  assign rd_addr = AW'(cnt_q - TWO_C);
  assign wr_addr = AW'(cnt_q - 1'b1);
  assign is_div  = (mode_q == MODE_DIV);

  // One 16-bit digit of the multiplier per step; only the low bits are kept.
  assign mul_prod = W'(op_a_q * op_b_q[DIGIT_W-1:0]);

  // Restoring division: op_a_q shifts the dividend out and the quotient in.
  assign div_rem_sh = {acc_q[W-2:0], op_a_q[W-1]};
  assign div_ge     = (div_rem_sh >= op_b_q);

  assign sts_o.long_op   = ex_long;
  assign sts_o.step_last = (it_q == (is_div ? DIV_LAST : MUL_LAST));

  always_comb begin
    mode_d   = mode_q;
    pv_d     = pv_q;
    tos_d    = tos_q;
    cnt_d    = cnt_q;
    op_a_d   = op_a_q;
    op_b_d   = op_b_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    it_d     = it_q;
    res_d    = res_q;
    depth_d  = depth_q;
    status_d = status_q;
    done_d   = 1'b0;
    mem_we   = 1'b0;
    ex_value = '0;
    ex_long  = 1'b0;

    if (cmd_i.accept) begin
      mode_d = mode_i;
      pv_d   = W'(push_value_i);
    end

    if (cmd_i.exec) begin
      status_d = STATUS_OK;
      unique case (mode_q) inside
        MODE_PUSH: begin
          if (cnt_q == DEPTH_C) begin
            status_d = STATUS_OVERFLOW;
          end else begin
            mem_we   = (cnt_q != '0);
            tos_d    = pv_q;
            cnt_d    = cnt_q + 1'b1;
            ex_value = pv_q;
          end
        end
        MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
          if (cnt_q < TWO_C) begin
            status_d = STATUS_UNDERFLOW;
          end else if (is_div && rd_q == '0) begin
            status_d = STATUS_DIV_ZERO;
          end else if (mode_q == MODE_ADD) begin
            ex_value = tos_q + rd_q;
            tos_d    = ex_value;
            cnt_d    = cnt_q - 1'b1;
          end else if (mode_q == MODE_SUB) begin
            ex_value = tos_q - rd_q;
            tos_d    = ex_value;
            cnt_d    = cnt_q - 1'b1;
          end else if (mode_q == MODE_MUL) begin
            ex_long = 1'b1;
            op_a_d  = tos_q;
            op_b_d  = rd_q;
            acc_d   = '0;
            it_d    = '0;
          end else begin
            ex_long = 1'b1;
            op_a_d  = mag_of(tos_q);
            op_b_d  = mag_of(rd_q);
            neg_d   = tos_q[W-1] ^ rd_q[W-1];
            acc_d   = '0;
            it_d    = '0;
          end
        end
        MODE_DROP: begin
          if (cnt_q == '0) begin
            status_d = STATUS_UNDERFLOW;
          end else begin
            ex_value = tos_q;
            tos_d    = rd_q;
            cnt_d    = cnt_q - 1'b1;
          end
        end
        default: begin
          ex_value = '0;
        end
      endcase
      done_d  = !ex_long;
      res_d   = VALUE_W'(ex_value);
      depth_d = DEPTH_OUT_W'(cnt_d);
    end

    if (cmd_i.step) begin
      it_d = it_q + 1'b1;
      if (is_div) begin
        acc_d  = div_ge ? (div_rem_sh - op_b_q) : div_rem_sh;
        op_a_d = {op_a_q[W-2:0], div_ge};
      end else begin
        acc_d  = acc_q + mul_prod;
        op_a_d = W'(op_a_q << DIGIT_W);
        op_b_d = W'(op_b_q >> DIGIT_W);
      end
    end

    if (cmd_i.finish) begin
      if (is_div) begin
        ex_value = neg_q ? (~op_a_q + 1'b1) : op_a_q;
      end else begin
        ex_value = acc_q;
      end
      tos_d    = ex_value;
      cnt_d    = cnt_q - 1'b1;
      status_d = STATUS_OK;
      done_d   = 1'b1;
      res_d    = VALUE_W'(ex_value);
      depth_d  = DEPTH_OUT_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= tos_q;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    pv_q     <= pv_d;
    tos_q    <= tos_d;
    op_a_q   <= op_a_d;
    op_b_q   <= op_b_d;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
    it_q     <= it_d;
    res_q    <= res_d;
    depth_q  <= depth_d;
    status_q <= status_d;
  end

  assign result_value_o = res_q;
  assign stack_depth_o  = depth_q;
  assign status_o       = status_q;
  assign done_o         = done_q;

endmodule

`default_nettype wire

// ----- rtl/core/stkcalc_checker.sv -----
// Port-level checker for the stack calculator and its bind.
`default_nettype none

`include "stack_calculator_macros.svh"

module stkcalc_checker import stkcalc_pkg::*; (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [MODE_W-1:0]          mode_i,
  input wire logic signed [VALUE_W-1:0]  push_value_i,
  input wire logic                       done_o,
  input wire logic signed [VALUE_W-1:0]  result_value_o,
  input wire logic [DEPTH_OUT_W-1:0]     stack_depth_o,
  input wire logic [STATUS_W-1:0]        status_o
);

  // Every request passes through the execute state after acceptance, so strobes never touch.
  `STKC_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, done_o, !done_o, "result strobe repeated")

  // The controller returns to idle in the same cycle the result appears.
  `STKC_ASSERT_NOW(a_strobe_ends_busy, clk_i, rst_ni, done_o, $fell(busy), "strobe without end of busy")

  `STKC_ASSERT_NOW(a_error_zero, clk_i, rst_ni, done_o && status_o != STATUS_OK, result_value_o == '0, "flagged result not zero")

  `STKC_ASSERT_NOW(a_underflow_depth, clk_i, rst_ni, done_o && status_o == STATUS_UNDERFLOW, stack_depth_o < 7'd2, "underflow with two or more entries")

endmodule

bind stack_calculator stkcalc_checker u_stkcalc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .mode_i         (mode_i),
  .push_value_i   (push_value_i),
  .done_o         (done_o),
  .result_value_o (result_value_o),
  .stack_depth_o  (stack_depth_o),
  .status_o       (status_o)
);

`default_nettype wire

// ----- verif/stack_calculator_checker.sv -----
// Checker that predicts every stack calculator result and compares it with the block's output.
`timescale 1ns / 1ps

module stack_calculator_checker import stkcalc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   busy,
  input  logic [MODE_W-1:0]      mode_i,
  input  logic [VALUE_W-1:0]     push_value_i,
  input  logic                   done_o,
  input  logic [VALUE_W-1:0]     result_value_o,
  input  logic [DEPTH_OUT_W-1:0] stack_depth_o,
  input  logic [STATUS_W-1:0]    status_o,
  output int                     mismatch_count,
  output int                     pending_count
);

  localparam int unsigned STACK_DEPTH = 64;

  typedef struct {
    logic [VALUE_W-1:0]     value;
    logic [DEPTH_OUT_W-1:0] depth;
    status_e                status;
  } calc_result_t;

  logic [VALUE_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned        fill;
  calc_result_t       expected_results [$];

  // Runs one request on the local copy of the stack and returns what the block must report.
  function automatic calc_result_t apply_operation(input logic [MODE_W-1:0] op,
                                                   input logic [VALUE_W-1:0] operand);
    calc_result_t       res;
    logic [VALUE_W-1:0] lhs;
    logic [VALUE_W-1:0] rhs;
    logic [VALUE_W-1:0] mag_l;
    logic [VALUE_W-1:0] mag_r;
    logic [VALUE_W-1:0] quo;
    res.value  = '0;
    res.status = STATUS_OK;
    case (op)
      MODE_PUSH: begin
        if (fill >= STACK_DEPTH) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          stack_mem[fill] = operand;
          fill++;
          res.value = operand;
        end
      end
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
        if (fill < 2) begin
          res.status = STATUS_UNDERFLOW;
        end else begin
          lhs = stack_mem[fill-1];
          rhs = stack_mem[fill-2];
          if (op == MODE_DIV && rhs == '0) begin
            res.status = STATUS_DIV_ZERO;
          end else begin
            if (op == MODE_ADD) begin
              res.value = lhs + rhs;
            end else if (op == MODE_SUB) begin
              res.value = lhs - rhs;
            end else if (op == MODE_MUL) begin
              res.value = lhs * rhs;
            end else begin
              // Unsigned magnitudes keep the most negative value exact, so it divided by
              // minus one wraps back to itself.
              mag_l = lhs[VALUE_W-1] ? -lhs : lhs;
              mag_r = rhs[VALUE_W-1] ? -rhs : rhs;
              quo   = mag_l / mag_r;
              res.value = (lhs[VALUE_W-1] ^ rhs[VALUE_W-1]) ? -quo : quo;
            end
            fill--;
            stack_mem[fill-1] = res.value;
          end
        end
      end
      MODE_DROP: begin
        if (fill < 1) begin
          res.status = STATUS_UNDERFLOW;
        end else begin
          fill--;
          res.value = stack_mem[fill];
        end
      end
      default: begin
      end
    endcase
    res.depth = fill[DEPTH_OUT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_results
    calc_result_t head;
    if (!rst_ni) begin
      expected_results.delete();
      fill = 0;
      mismatch_count <= 0;
      pending_count  <= 0;
    end else begin
      // Compare before queuing: a request taken at this edge cannot be answered at it.
      if (done_o) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result with no request waiting: value %0d depth %0d status %0d",
                     $realtime, $signed(result_value_o), stack_depth_o, status_o);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          head = expected_results.pop_front();
          if (result_value_o !== head.value || stack_depth_o !== head.depth ||
              status_o !== head.status) begin
            if (mismatch_count < 10) begin
              $display("%0t: expected value %0d depth %0d status %0d, got value %0d depth %0d status %0d",
                       $realtime, $signed(head.value), head.depth, head.status,
                       $signed(result_value_o), stack_depth_o, status_o);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_operation(mode_i, push_value_i));
      end
      pending_count <= expected_results.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the stack calculator: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import stkcalc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  // Longest operation is a divide.
  localparam int unsigned DRAIN_CYCLES = 40;

  localparam logic [MODE_W-1:0]  MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0]  MODE_SPARE_HI = 3'd7;
  localparam logic [VALUE_W-1:0] VALUE_MIN     = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VALUE_MAX     = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VALUE_NEG_ONE = 32'hffff_ffff;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [MODE_W-1:0]          mode_i;
  logic signed [VALUE_W-1:0]  push_value_i;
  logic                       done_o;
  logic signed [VALUE_W-1:0]  result_value_o;
  logic [DEPTH_OUT_W-1:0]     stack_depth_o;
  logic [STATUS_W-1:0]        status_o;
  int                         mismatch_count;
  int                         pending_count;
  int unsigned                cycle_count;

  stack_calculator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .push_value_i  (push_value_i),
    .done_o        (done_o),
    .result_value_o(result_value_o),
    .stack_depth_o (stack_depth_o),
    .status_o      (status_o)
  );

  stack_calculator_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .push_value_i  (push_value_i),
    .done_o        (done_o),
    .result_value_o(result_value_o),
    .stack_depth_o (stack_depth_o),
    .status_o      (status_o),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Holds the request until the block takes it; returns at the accepting edge.
  task automatic issue_request(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] operand);
    mode_i       <= op;
    push_value_i <= operand;
    start        <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stops sending and waits for every outstanding result; the count is read mid-cycle.
  task automatic wait_until_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Extremes and small values are favored so that zero divisors and wraps come up often.
  function automatic logic [VALUE_W-1:0] pick_operand();
    logic [VALUE_W-1:0] val;
    case ($urandom_range(9))
      0:       val = '0;
      1:       val = 32'd1;
      2:       val = VALUE_NEG_ONE;
      3:       val = VALUE_MIN;
      4:       val = VALUE_MAX;
      5:       val = $urandom_range(15) - 8;
      default: val = $urandom;
    endcase
    return val;
  endfunction

  initial begin : stimulus
    int unsigned       seg_left;
    int unsigned       push_pct;
    int unsigned       idle_pct;
    logic [MODE_W-1:0] op;

    seg_left = 0;
    push_pct = 50;
    start        <= 1'b0;
    mode_i       <= MODE_PUSH;
    push_value_i <= '0;
    rst_ni       <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty and single-entry underflow.
    issue_request(MODE_DROP, 32'd0);
    issue_request(MODE_ADD, 32'd0);
    issue_request(MODE_PUSH, VALUE_MAX);
    issue_request(MODE_SUB, 32'd0);
    // Most negative divided by minus one.
    issue_request(MODE_PUSH, VALUE_NEG_ONE);
    issue_request(MODE_PUSH, VALUE_MIN);
    issue_request(MODE_DIV, 32'd0);
    // Divide by zero leaves the stack alone.
    issue_request(MODE_PUSH, 32'd0);
    issue_request(MODE_PUSH, 32'd5);
    issue_request(MODE_DIV, 32'd0);
    issue_request(MODE_DROP, 32'd0);
    issue_request(MODE_DROP, 32'd0);
    issue_request(MODE_ADD, 32'd0);
    issue_request(MODE_PUSH, 32'd3);
    issue_request(MODE_MUL, 32'd0);
    issue_request(MODE_PUSH, 32'd7);
    issue_request(MODE_SUB, 32'd0);
    issue_request(MODE_SPARE_LO, VALUE_MAX);
    issue_request(MODE_SPARE_HI, VALUE_MIN);
    issue_request(MODE_DROP, 32'd0);
    issue_request(MODE_DROP, 32'd0);

    // Each segment is picked at random as filling, churning or draining so that both the full and
    // the empty stack are reached many times.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(90, 10);
        case ($urandom_range(2))
          0:       push_pct = 92;
          1:       push_pct = 55;
          default: push_pct = 20;
        endcase
      end
      seg_left--;
      idle_pct = (n < RANDOM_ITEMS / 3) ? 11 : (n < 2 * RANDOM_ITEMS / 3) ? 61 : 0;
      if (n == RANDOM_ITEMS / 2) begin
        wait_until_drained();
      end
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
      if ($urandom_range(99) < push_pct) begin
        op = MODE_PUSH;
      end else begin
        case ($urandom_range(19))
          0, 1, 2, 3:         op = MODE_ADD;
          4, 5, 6:            op = MODE_SUB;
          7, 8, 9:            op = MODE_MUL;
          10, 11, 12:         op = MODE_DIV;
          13, 14, 15, 16, 17: op = MODE_DROP;
          18:                 op = MODE_SPARE_LO;
          default:            op = MODE_SPARE_HI;
        endcase
      end
      issue_request(op, pick_operand());
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
